### hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and tables for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BlockW = 512;

  localparam logic [ByteW-1:0] PadByte   = 8'h80;
  localparam logic [5:0]       LastFill  = 6'd63;
  localparam logic [5:0]       LenStart  = 6'd55;
  localparam logic [5:0]       LastRound = 6'd63;
  localparam logic [2:0]       LastWord  = 3'd7;
  localparam logic             FuncAppend = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] msg_byte;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [2:0]       word_index;
    logic             digest_last;
  } out_beat_t;

  // Block store / schedule control
  typedef struct packed {
    logic             shift_byte;
    logic [ByteW-1:0] byte_val;
    logic             shift_word;
  } sched_ctrl_t;

  // Round unit control
  typedef struct packed {
    logic load;
    logic round;
    logic fold;
    logic reinit;
  } core_ctrl_t;

  function automatic logic [WordW-1:0] init_hash(input logic [2:0] idx);
    logic [WordW-1:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      3'd7:    v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
    logic [WordW-1:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 over a byte stream, one round per cycle on a single round unit.
// ----------------------------------------------------------------------------
// An append beat is taken on acceptance; the 64th byte of a block also runs the
// rounds and a fold before the next beat is taken.
// A finish beat with n bytes pending is accepted, then padding/length bytes fill
// the block and it is compressed (two compressions when n > 55, the second
// block holding only padding and length), then 8 output beats at one per cycle
// while out_stall_i is low.
// The round unit and its sequencer handle one beat at a time.
// Reset clears the sequencer and counters and loads the initial hash values;
// the block store holds whatever it held until bytes shift into it.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top import shs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  state_e state_q, state_d;

  // Byte fill level of the block store, wraps at 64 bytes
  logic [5:0]  fill_q, fill_d;
  // Round counter of the running compression
  logic [5:0]  round_q, round_d;
  // Digest word being presented
  logic [2:0]  idx_q, idx_d;
  // Bits of all full blocks; on finish it holds the total length and is
  // shifted out byte by byte, leaving zero for the next message
  logic [63:0] bitcnt_q, bitcnt_d;
  logic        padfirst_q, padfirst_d;
  logic        final_q, final_d;
  logic        append_q, append_d;

  logic        in_acc, out_acc, is_append;
  sched_ctrl_t sched_ctrl;
  core_ctrl_t  core_ctrl;
  logic [WordW-1:0] w_word, k_word, dig_word;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign is_append = (in_data_i.func == FuncAppend);
  assign k_word    = round_k(round_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_append) begin
            state_d = ST_PAD;
          end else if (fill_q == LastFill) begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        // Full block goes first; at 56 bytes the length field follows
        if (fill_q == LastFill) begin
          state_d = ST_ROUND;
        end else if (fill_q == LenStart) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (fill_q == LastFill) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_q == LastRound) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (append_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control; the stall is low in idle, so a valid beat
  // there is taken
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    sched_ctrl  = '0;
    core_ctrl   = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && is_append) begin
          sched_ctrl.shift_byte = 1'b1;
          sched_ctrl.byte_val   = in_data_i.msg_byte;
          core_ctrl.load        = (fill_q == LastFill);
        end
      end
      ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_val   = padfirst_q ? PadByte : '0;
        core_ctrl.load        = (fill_q == LastFill);
      end
      ST_LEN: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_val   = bitcnt_q[63:56];
        core_ctrl.load        = (fill_q == LastFill);
      end
      ST_ROUND: begin
        sched_ctrl.shift_word = 1'b1;
        core_ctrl.round       = 1'b1;
      end
      ST_FOLD: begin
        core_ctrl.fold = 1'b1;
      end
      ST_OUT: begin
        out_valid_o      = 1'b1;
        core_ctrl.reinit = !out_stall_i && (idx_q == LastWord);
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Counters and flags
  always_comb begin
    fill_d     = fill_q;
    round_d    = round_q;
    idx_d      = idx_q;
    bitcnt_d   = bitcnt_q;
    padfirst_d = padfirst_q;
    final_d    = final_q;
    append_d   = append_q;
    if (sched_ctrl.shift_byte) begin
      fill_d = fill_q + 6'd1;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !is_append) begin
          // Total length: full blocks plus the pending bytes
          bitcnt_d   = bitcnt_q + {55'd0, fill_q, 3'd0};
          padfirst_d = 1'b1;
        end
        append_d = 1'b1;
        final_d  = 1'b0;
      end
      ST_PAD: begin
        padfirst_d = 1'b0;
        append_d   = 1'b0;
        final_d    = 1'b0;
      end
      ST_LEN: begin
        bitcnt_d = {bitcnt_q[55:0], 8'd0};
        append_d = 1'b0;
        final_d  = 1'b1;
      end
      ST_ROUND: begin
        round_d = round_q + 6'd1;
      end
      ST_FOLD: begin
        if (append_q) begin
          bitcnt_d = bitcnt_q + 64'd512;
        end
        idx_d = '0;
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      round_q    <= '0;
      idx_q      <= '0;
      bitcnt_q   <= '0;
      padfirst_q <= 1'b0;
      final_q    <= 1'b0;
      append_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
      bitcnt_q   <= bitcnt_d;
      padfirst_q <= padfirst_d;
      final_q    <= final_d;
      append_q   <= append_d;
    end
  end

  shs_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_word)
  );

  shs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .k_i    (k_word),
    .w_i    (w_word),
    .sel_i  (idx_q),
    .word_o (dig_word)
  );

  // Hold the digest word steady from registers while the beat is stalled
  assign out_data_o.digest_word = dig_word;
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.digest_last = (idx_q == LastWord);

endmodule

### hw/rtl/shs_sched.sv
// ----------------------------------------------------------------------------
// shs_sched
// Block store and message schedule: one 512-bit shift line that takes bytes
// while filling and then slides one schedule word per round.
// ----------------------------------------------------------------------------
module shs_sched import shs_pkg::*; (
  input  logic             clk_i,
  input  sched_ctrl_t      ctrl_i,
  output logic [WordW-1:0] w_o
);

  logic [BlockW-1:0] store_q, store_d;
  logic [WordW-1:0]  w0, w1, w9, w14, s0, s1, w_new;

  assign w0  = store_q[511:480];
  assign w1  = store_q[479:448];
  assign w9  = store_q[223:192];
  assign w14 = store_q[63:32];

  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign w_o = w0;

  always_comb begin
    store_d = store_q;
    if (ctrl_i.shift_byte) begin
      store_d = {store_q[BlockW-ByteW-1:0], ctrl_i.byte_val};
    end else if (ctrl_i.shift_word) begin
      store_d = {store_q[BlockW-WordW-1:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

### hw/rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Round unit: working variables, one SHA-256 round per cycle, and the
// chaining value that the finished block folds into.
// ----------------------------------------------------------------------------
module shs_core import shs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  core_ctrl_t       ctrl_i,
  input  logic [WordW-1:0] k_i,
  input  logic [WordW-1:0] w_i,
  input  logic [2:0]       sel_i,
  output logic [WordW-1:0] word_o
);

  logic [WordW-1:0] chain_q [8];
  logic [WordW-1:0] chain_d [8];
  logic [WordW-1:0] work_q  [8];
  logic [WordW-1:0] work_d  [8];
  logic [WordW-1:0] a, b, c, e, f, g, h, sig0, sig1, ch, maj, t1, t2;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign e = work_q[4];
  assign f = work_q[5];
  assign g = work_q[6];
  assign h = work_q[7];

  assign sig1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign sig0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch   = (e & f) ^ (~e & g);
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t1   = h + sig1 + ch + k_i + w_i;
  assign t2   = sig0 + maj;

  assign word_o = chain_q[sel_i];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      work_d[i]  = work_q[i];
      chain_d[i] = chain_q[i];
    end
    if (ctrl_i.load) begin
      for (int i = 0; i < 8; i++) begin
        work_d[i] = chain_q[i];
      end
    end else if (ctrl_i.round) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
    if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end else if (ctrl_i.reinit) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = init_hash(3'(i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      work_q[i] <= work_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= init_hash(3'(i));
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

endmodule
